// File: hw/rtl/kf_pkg.sv
// kf_pkg: transaction types, fixed-point constants and saturation helpers
// for the Kalman filter step block. No dependencies.
package kf_pkg;

  localparam int COEF_BITS = 12;
  localparam int NCFG      = 7;

  localparam logic [2:0] CFG_A    = 3'd0;
  localparam logic [2:0] CFG_BH   = 3'd1;
  localparam logic [2:0] CFG_QD   = 3'd2;
  localparam logic [2:0] CFG_QR   = 3'd3;
  localparam logic [2:0] CFG_X0   = 3'd4;
  localparam logic [2:0] CFG_PD   = 3'd5;
  localparam logic [2:0] CFG_POFF = 3'd6;

  localparam logic [1:0] K_MAC = 2'd0;
  localparam logic [1:0] K_WR  = 2'd1;
  localparam logic [1:0] K_DIV = 2'd2;

  localparam logic signed [65:0] MAX32 = 66'sh0_7FFF_FFFF;
  localparam logic signed [65:0] MIN32 = -66'sh0_8000_0000;

  typedef struct packed {
    logic               command;
    logic signed [31:0] measurement;
    logic signed [31:0] control;
  } kf_in_t;

  typedef struct packed {
    logic signed [31:0] estimate_0;
    logic signed [31:0] estimate_1;
    logic signed [31:0] gain_0;
    logic signed [31:0] gain_1;
    logic signed [31:0] cov_00;
    logic signed [31:0] cov_01;
    logic signed [31:0] cov_11;
    logic               singular_flag;
    logic               saturated_flag;
  } kf_out_t;

  // one sequencer step
  typedef struct packed {
    logic [1:0] kind;
    logic       clr;
    logic       fr;
    logic       r12;
    logic       presat;
    logic       neg;
    logic       use_acc;
    logic [4:0] dest;
  } kf_uop_t;

  function automatic logic ovf32(input logic signed [65:0] v);
    return (v > MAX32) || (v < MIN32);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > MAX32) return 32'sh7FFF_FFFF;
    else if (v < MIN32) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

  function automatic logic signed [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

// File: hw/rtl/kalman_filter_step.sv
// kalman_filter_step: two-state fixed-point Kalman filter, Joseph-form update.
// Depends on kf_pkg and kf_div.
//
//  port group | direction | transaction
//  in_*       | input     | command, measurement, control (kf_in_t)
//  out_*      | output    | estimate, gain, covariance, flags (kf_out_t)
//  cfg_*      | input     | register write, index 0..6, 64-bit data
//
// A filter step runs a program of 84 sequencer steps on one shared 32x32
// multiply-accumulate; each of the two gain steps holds for a serial division, and a
// singular step skips both divisions. The next transaction is taken once the result
// has gone to the output register; a restart loads the configured state and covariance.
// in_stall stays high while a transaction is in work. A finished result waits in the
// output register. rst_n clears configuration, state estimate, covariance and last control.
module kalman_filter_step
  import kf_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  kf_in_t      in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output kf_out_t     out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam int QW = 33 + FRAC_BITS;
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam logic [6:0] LAST_STEP = 7'd83;
  localparam logic [6:0] DIV0_STEP = 7'd38;
  localparam logic [6:0] G_STEP    = 7'd40;

  localparam logic [4:0] D_XE0 = 5'd0,  D_XE1 = 5'd1,  D_T00 = 5'd2,  D_T01 = 5'd3;
  localparam logic [4:0] D_T10 = 5'd4,  D_T11 = 5'd5,  D_M00 = 5'd6,  D_M01 = 5'd7;
  localparam logic [4:0] D_M11 = 5'd8,  D_C0  = 5'd9,  D_C1  = 5'd10, D_S   = 5'd11;
  localparam logic [4:0] D_G00 = 5'd12, D_G01 = 5'd13, D_G10 = 5'd14, D_G11 = 5'd15;
  localparam logic [4:0] D_U00 = 5'd16, D_U01 = 5'd17, D_U10 = 5'd18, D_U11 = 5'd19;
  localparam logic [4:0] D_W0  = 5'd20, D_W1  = 5'd21, D_P00 = 5'd22, D_P01 = 5'd23;
  localparam logic [4:0] D_P11 = 5'd24, D_HX  = 5'd25, D_INN = 5'd26, D_X0  = 5'd27;
  localparam logic [4:0] D_X1  = 5'd28;

  logic [63:0] cfg_r [NCFG-1];
  logic signed [31:0] poff_r;

  logic [1:0] state_r;
  logic [6:0] step_r;
  logic       div_wait_r, div_start_r, sing_r, satf_r, out_valid_r;
  kf_out_t    out_data_r;

  logic signed [31:0] x0_r, x1_r, p00_r, p01_r, p11_r, lastu_r, meas_r, ctrl_r;
  logic signed [31:0] xe0_r, xe1_r, t00_r, t01_r, t10_r, t11_r, m00_r, m01_r, m11_r;
  logic signed [31:0] c0_r, c1_r, s_r, k0_r, k1_r, g00_r, g01_r, g10_r, g11_r;
  logic signed [31:0] u00_r, u01_r, u10_r, u11_r, w0_r, w1_r, hx_r, inn_r;
  logic signed [63:0] acc_r, acc_nxt, prod, term;

  logic signed [31:0] a00, a01, a10, a11, b0, b1, h0, h1, q00, q01, q11, rr;
  logic signed [31:0] opa, opb, wv, csel, kv;
  logic signed [65:0] addend, core, core2, sum, qx, kq;
  logic signed [32:0] cx, cneg;
  logic [31:0]        mag;
  logic               wovf, kovf, div_done;
  logic [QW-1:0]      quo;
  kf_uop_t            u;

  localparam logic signed [65:0] ONE  = 66'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  assign a00 = sext16(cfg_r[CFG_A][15:0]);
  assign a01 = sext16(cfg_r[CFG_A][31:16]);
  assign a10 = sext16(cfg_r[CFG_A][47:32]);
  assign a11 = sext16(cfg_r[CFG_A][63:48]);
  assign b0  = sext16(cfg_r[CFG_BH][15:0]);
  assign b1  = sext16(cfg_r[CFG_BH][31:16]);
  assign h0  = sext16(cfg_r[CFG_BH][47:32]);
  assign h1  = sext16(cfg_r[CFG_BH][63:48]);
  assign q00 = cfg_r[CFG_QD][31:0];
  assign q11 = cfg_r[CFG_QD][63:32];
  assign q01 = cfg_r[CFG_QR][31:0];
  assign rr  = cfg_r[CFG_QR][63:32];

  // step program
  always_comb begin
    u      = '{kind: K_MAC, dest: 5'd0, default: 1'b0};
    opa    = '0;
    opb    = '0;
    addend = '0;
    unique case (step_r)
      7'd0:  begin u.clr = 1'b1; opa = b0;  opb = lastu_r; end
      7'd1:  begin opa = a00; opb = x0_r; end
      7'd2:  begin opa = a01; opb = x1_r; end
      7'd3:  begin u.kind = K_WR; u.dest = D_XE0; u.r12 = 1'b1; u.use_acc = 1'b1; end
      7'd4:  begin u.clr = 1'b1; opa = b1;  opb = lastu_r; end
      7'd5:  begin opa = a10; opb = x0_r; end
      7'd6:  begin opa = a11; opb = x1_r; end
      7'd7:  begin u.kind = K_WR; u.dest = D_XE1; u.r12 = 1'b1; u.use_acc = 1'b1; end
      7'd8:  begin u.clr = 1'b1; opa = a00; opb = p00_r; end
      7'd9:  begin opa = a01; opb = p01_r; end
      7'd10: begin u.kind = K_WR; u.dest = D_T00; u.r12 = 1'b1; u.use_acc = 1'b1; end
      7'd11: begin u.clr = 1'b1; opa = a00; opb = p01_r; end
      7'd12: begin opa = a01; opb = p11_r; end
      7'd13: begin u.kind = K_WR; u.dest = D_T01; u.r12 = 1'b1; u.use_acc = 1'b1; end
      7'd14: begin u.clr = 1'b1; opa = a10; opb = p00_r; end
      7'd15: begin opa = a11; opb = p01_r; end
      7'd16: begin u.kind = K_WR; u.dest = D_T10; u.r12 = 1'b1; u.use_acc = 1'b1; end
      7'd17: begin u.clr = 1'b1; opa = a10; opb = p01_r; end
      7'd18: begin opa = a11; opb = p11_r; end
      7'd19: begin u.kind = K_WR; u.dest = D_T11; u.r12 = 1'b1; u.use_acc = 1'b1; end
      7'd20: begin u.clr = 1'b1; opa = t00_r; opb = a00; end
      7'd21: begin opa = t01_r; opb = a01; end
      7'd22: begin
        u.kind = K_WR; u.dest = D_M00; u.r12 = 1'b1; u.presat = 1'b1; u.use_acc = 1'b1;
        addend = 66'(q00);
      end
      7'd23: begin u.clr = 1'b1; opa = t00_r; opb = a10; end
      7'd24: begin opa = t01_r; opb = a11; end
      7'd25: begin
        u.kind = K_WR; u.dest = D_M01; u.r12 = 1'b1; u.presat = 1'b1; u.use_acc = 1'b1;
        addend = 66'(q01);
      end
      7'd26: begin u.clr = 1'b1; opa = t10_r; opb = a10; end
      7'd27: begin opa = t11_r; opb = a11; end
      7'd28: begin
        u.kind = K_WR; u.dest = D_M11; u.r12 = 1'b1; u.presat = 1'b1; u.use_acc = 1'b1;
        addend = 66'(q11);
      end
      7'd29: begin u.clr = 1'b1; opa = m00_r; opb = h0; end
      7'd30: begin opa = m01_r; opb = h1; end
      7'd31: begin u.kind = K_WR; u.dest = D_C0; u.r12 = 1'b1; u.use_acc = 1'b1; end
      7'd32: begin u.clr = 1'b1; opa = m01_r; opb = h0; end
      7'd33: begin opa = m11_r; opb = h1; end
      7'd34: begin u.kind = K_WR; u.dest = D_C1; u.r12 = 1'b1; u.use_acc = 1'b1; end
      7'd35: begin u.clr = 1'b1; opa = h0; opb = c0_r; end
      7'd36: begin opa = h1; opb = c1_r; end
      7'd37: begin
        u.kind = K_WR; u.dest = D_S; u.r12 = 1'b1; u.presat = 1'b1; u.use_acc = 1'b1;
        addend = 66'(rr);
      end
      7'd38: u.kind = K_DIV;
      7'd39: u.kind = K_DIV;
      7'd40: begin u.clr = 1'b1; opa = k0_r; opb = h0; end
      7'd41: begin
        u.kind = K_WR; u.dest = D_G00; u.r12 = 1'b1; u.neg = 1'b1; u.use_acc = 1'b1;
        addend = ONE;
      end
      7'd42: begin u.clr = 1'b1; opa = k0_r; opb = h1; end
      7'd43: begin u.kind = K_WR; u.dest = D_G01; u.r12 = 1'b1; u.neg = 1'b1; u.use_acc = 1'b1; end
      7'd44: begin u.clr = 1'b1; opa = k1_r; opb = h0; end
      7'd45: begin u.kind = K_WR; u.dest = D_G10; u.r12 = 1'b1; u.neg = 1'b1; u.use_acc = 1'b1; end
      7'd46: begin u.clr = 1'b1; opa = k1_r; opb = h1; end
      7'd47: begin
        u.kind = K_WR; u.dest = D_G11; u.r12 = 1'b1; u.neg = 1'b1; u.use_acc = 1'b1;
        addend = ONE;
      end
      7'd48: begin u.clr = 1'b1; u.fr = 1'b1; opa = g00_r; opb = m00_r; end
      7'd49: begin u.fr = 1'b1; opa = g01_r; opb = m01_r; end
      7'd50: begin u.kind = K_WR; u.dest = D_U00; u.use_acc = 1'b1; end
      7'd51: begin u.clr = 1'b1; u.fr = 1'b1; opa = g00_r; opb = m01_r; end
      7'd52: begin u.fr = 1'b1; opa = g01_r; opb = m11_r; end
      7'd53: begin u.kind = K_WR; u.dest = D_U01; u.use_acc = 1'b1; end
      7'd54: begin u.clr = 1'b1; u.fr = 1'b1; opa = g10_r; opb = m00_r; end
      7'd55: begin u.fr = 1'b1; opa = g11_r; opb = m01_r; end
      7'd56: begin u.kind = K_WR; u.dest = D_U10; u.use_acc = 1'b1; end
      7'd57: begin u.clr = 1'b1; u.fr = 1'b1; opa = g10_r; opb = m01_r; end
      7'd58: begin u.fr = 1'b1; opa = g11_r; opb = m11_r; end
      7'd59: begin u.kind = K_WR; u.dest = D_U11; u.use_acc = 1'b1; end
      7'd60: begin u.clr = 1'b1; u.fr = 1'b1; opa = k0_r; opb = rr; end
      7'd61: begin u.kind = K_WR; u.dest = D_W0; u.use_acc = 1'b1; end
      7'd62: begin u.clr = 1'b1; u.fr = 1'b1; opa = k1_r; opb = rr; end
      7'd63: begin u.kind = K_WR; u.dest = D_W1; u.use_acc = 1'b1; end
      7'd64: begin u.clr = 1'b1; u.fr = 1'b1; opa = w0_r; opb = k0_r; end
      7'd65: begin u.fr = 1'b1; opa = u00_r; opb = g00_r; end
      7'd66: begin u.fr = 1'b1; opa = u01_r; opb = g01_r; end
      7'd67: begin u.kind = K_WR; u.dest = D_P00; u.use_acc = 1'b1; end
      7'd68: begin u.clr = 1'b1; u.fr = 1'b1; opa = w0_r; opb = k1_r; end
      7'd69: begin u.fr = 1'b1; opa = u00_r; opb = g10_r; end
      7'd70: begin u.fr = 1'b1; opa = u01_r; opb = g11_r; end
      7'd71: begin u.kind = K_WR; u.dest = D_P01; u.use_acc = 1'b1; end
      7'd72: begin u.clr = 1'b1; u.fr = 1'b1; opa = w1_r; opb = k1_r; end
      7'd73: begin u.fr = 1'b1; opa = u10_r; opb = g10_r; end
      7'd74: begin u.fr = 1'b1; opa = u11_r; opb = g11_r; end
      7'd75: begin u.kind = K_WR; u.dest = D_P11; u.use_acc = 1'b1; end
      7'd76: begin u.clr = 1'b1; opa = h0; opb = xe0_r; end
      7'd77: begin opa = h1; opb = xe1_r; end
      7'd78: begin
        u.kind = K_WR; u.dest = D_HX; u.r12 = 1'b1; u.presat = 1'b1; u.use_acc = 1'b1;
      end
      7'd79: begin
        u.kind = K_WR; u.dest = D_INN; u.neg = 1'b1; opa = hx_r; addend = 66'(meas_r);
      end
      7'd80: begin u.clr = 1'b1; u.fr = 1'b1; opa = k0_r; opb = inn_r; end
      7'd81: begin u.kind = K_WR; u.dest = D_X0; u.use_acc = 1'b1; addend = 66'(xe0_r); end
      7'd82: begin u.clr = 1'b1; u.fr = 1'b1; opa = k1_r; opb = inn_r; end
      7'd83: begin u.kind = K_WR; u.dest = D_X1; u.use_acc = 1'b1; addend = 66'(xe1_r); end
      default: u.kind = K_WR;
    endcase
  end

  // shared multiply-accumulate
  assign prod    = opa * opb;
  assign term    = u.fr ? (prod + HALF) >>> FRAC_BITS : prod;
  assign acc_nxt = (u.clr ? 64'sd0 : acc_r) + term;

  // write-back: round, saturate, negate, add, saturate
  always_comb begin
    if (!u.use_acc) core = 66'(opa);
    else if (u.r12) core = (66'(acc_r) + 66'sd2048) >>> COEF_BITS;
    else core = 66'(acc_r);
    core2 = u.presat ? 66'(sat32(core)) : core;
    if (u.neg) core2 = -core2;
    sum  = core2 + addend;
    wv   = sat32(sum);
    wovf = (u.presat && ovf32(core)) || ovf32(sum);
  end

  // divider operands and signed gain
  assign csel = (step_r == DIV0_STEP) ? c0_r : c1_r;
  assign cx   = {csel[31], csel};
  assign cneg = -cx;
  assign mag  = csel[31] ? cneg[31:0] : csel;
  assign qx   = 66'(quo);
  assign kq   = csel[31] ? -qx : qx;
  assign kv   = sat32(kq);
  assign kovf = ovf32(kq);

  kf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .mag   (mag),
    .den   (s_r),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      div_wait_r  <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NCFG - 1; i++) cfg_r[i] <= '0;
      poff_r  <= '0;
      x0_r    <= '0;
      x1_r    <= '0;
      p00_r   <= '0;
      p01_r   <= '0;
      p11_r   <= '0;
      lastu_r <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_POFF) poff_r <= cfg_wdata[31:0];
        else if (cfg_index < CFG_POFF) cfg_r[cfg_index] <= cfg_wdata;
      end
      div_start_r <= 1'b0;
      if (state_r == ST_FIN && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            k0_r   <= '0;
            k1_r   <= '0;
            sing_r <= 1'b0;
            satf_r <= 1'b0;
            if (in_data.command) begin
              x0_r    <= cfg_r[CFG_X0][31:0];
              x1_r    <= cfg_r[CFG_X0][63:32];
              p00_r   <= cfg_r[CFG_PD][31:0];
              p11_r   <= cfg_r[CFG_PD][63:32];
              p01_r   <= poff_r;
              state_r <= ST_FIN;
            end else begin
              meas_r  <= in_data.measurement;
              ctrl_r  <= in_data.control;
              step_r  <= '0;
              state_r <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          unique case (u.kind)
            K_MAC: begin
              acc_r  <= acc_nxt;
              step_r <= step_r + 7'd1;
            end
            K_DIV: begin
              if (!div_wait_r) begin
                if (step_r == DIV0_STEP && s_r <= 32'sd0) begin
                  sing_r <= 1'b1;
                  step_r <= G_STEP;
                end else begin
                  div_start_r <= 1'b1;
                  div_wait_r  <= 1'b1;
                end
              end else if (div_done) begin
                if (step_r == DIV0_STEP) k0_r <= kv;
                else k1_r <= kv;
                satf_r     <= satf_r | kovf;
                div_wait_r <= 1'b0;
                step_r     <= step_r + 7'd1;
              end
            end
            default: begin
              satf_r <= satf_r | wovf;
              unique case (u.dest)
                D_XE0: xe0_r <= wv;
                D_XE1: xe1_r <= wv;
                D_T00: t00_r <= wv;
                D_T01: t01_r <= wv;
                D_T10: t10_r <= wv;
                D_T11: t11_r <= wv;
                D_M00: m00_r <= wv;
                D_M01: m01_r <= wv;
                D_M11: m11_r <= wv;
                D_C0:  c0_r  <= wv;
                D_C1:  c1_r  <= wv;
                D_S:   s_r   <= wv;
                D_G00: g00_r <= wv;
                D_G01: g01_r <= wv;
                D_G10: g10_r <= wv;
                D_G11: g11_r <= wv;
                D_U00: u00_r <= wv;
                D_U01: u01_r <= wv;
                D_U10: u10_r <= wv;
                D_U11: u11_r <= wv;
                D_W0:  w0_r  <= wv;
                D_W1:  w1_r  <= wv;
                D_P00: p00_r <= wv;
                D_P01: p01_r <= wv;
                D_P11: p11_r <= wv;
                D_HX:  hx_r  <= wv;
                D_INN: inn_r <= wv;
                D_X0:  x0_r  <= wv;
                D_X1:  x1_r  <= wv;
                default: ;
              endcase
              if (step_r == LAST_STEP) begin
                lastu_r <= ctrl_r;
                state_r <= ST_FIN;
              end else begin
                step_r <= step_r + 7'd1;
              end
            end
          endcase
        end
        ST_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r.estimate_0     <= x0_r;
            out_data_r.estimate_1     <= x1_r;
            out_data_r.gain_0         <= k0_r;
            out_data_r.gain_1         <= k1_r;
            out_data_r.cov_00         <= p00_r;
            out_data_r.cov_01         <= p01_r;
            out_data_r.cov_11         <= p11_r;
            out_data_r.singular_flag  <= sing_r;
            out_data_r.saturated_flag <= satf_r;
            state_r                   <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_sing_gain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.singular_flag |-> out_data.gain_0 == 32'sd0 && out_data.gain_1 == 32'sd0)
    else $error("singular result carries a nonzero gain");

  a_div_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_RUN && div_wait_r && (step_r == DIV0_STEP || step_r == 7'd39))
    else $error("divider finished outside a gain step");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == ST_FIN)
    else $error("result raised without a finished transaction");

endmodule

// File: hw/rtl/kf_div.sv
// kf_div: restoring divider, one quotient bit per cycle.
// Computes (mag * 2^FRAC_BITS + den/2) / den for a positive divisor. Uses nothing else.
module kf_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [31:0]            mag,
  input  logic [31:0]            den,
  output logic                   done,
  output logic [33+FRAC_BITS-1:0] quo
);

  localparam int QW = 33 + FRAC_BITS;
  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0] num_r, quo_r, numer;
  logic [32:0]   rem_r, rem_sh;
  logic [CW-1:0] cnt_r;
  logic          run_r, done_r, ge;

  assign numer  = ({{(QW-32){1'b0}}, mag} << FRAC_BITS) + QW'(den >> 1);
  assign rem_sh = {rem_r[31:0], num_r[QW-1]};
  assign ge     = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        num_r <= numer;
        rem_r <= '0;
        quo_r <= '0;
        cnt_r <= CW'(QW);
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= ge ? rem_sh - {1'b0, den} : rem_sh;
        num_r <= num_r << 1;
        quo_r <= {quo_r[QW-2:0], ge};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// File: dv/tb.sv
// tb: self-checking bench for kalman_filter_step, with directed and random traffic.
// Holds a scoreboard class that predicts every result from the configuration state.
// Depends on kf_pkg and the kalman_filter_step RTL.
module tb;
  import kf_pkg::*;

  localparam int FRAC = 16;
  localparam int WDOG_LIMIT = 6000;

  class kf_scoreboard;
    logic [63:0] regs [NCFG];
    longint x_est [2];
    longint p_cov [3];
    longint u_prev;
    bit clamp;
    kf_out_t pending [$];
    int mismatches;
    int n_step, n_restart, n_singular, n_sat, n_checked;

    function new();
      foreach (regs[i]) regs[i] = '0;
      x_est[0] = 0; x_est[1] = 0;
      p_cov[0] = 0; p_cov[1] = 0; p_cov[2] = 0;
      u_prev = 0;
      mismatches = 0;
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) begin
        clamp = 1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        clamp = 1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function longint rnd(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function longint h16(logic [63:0] w, int pos);
      logic [15:0] f;
      f = w[pos +: 16];
      return longint'($signed(f));
    endfunction

    function longint w32(logic [63:0] w, int pos);
      logic [31:0] f;
      f = w[pos +: 32];
      return longint'($signed(f));
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] val);
      regs[idx] = val;
    endfunction

    function void reload();
      x_est[0] = w32(regs[CFG_X0], 0);
      x_est[1] = w32(regs[CFG_X0], 32);
      p_cov[0] = w32(regs[CFG_PD], 0);
      p_cov[1] = w32(regs[CFG_POFF], 0);
      p_cov[2] = w32(regs[CFG_PD], 32);
    endfunction

    function void note_input(kf_in_t t);
      longint a [2][2], q [2][2], p [2][2], tm [2][2], m [2][2], g [2][2];
      longint um [2][2], np [2][2];
      longint b [2], h [2], xe [2], c [2], k [2], w [2];
      longint r, acc, s, hx, inn, mag, quo;
      bit singular;
      kf_out_t o;
      clamp = 0;
      singular = 0;
      k[0] = 0; k[1] = 0;
      if (t.command) begin
        reload();
        n_restart++;
        o.estimate_0 = x_est[0][31:0];
        o.estimate_1 = x_est[1][31:0];
        o.gain_0 = '0;
        o.gain_1 = '0;
        o.cov_00 = p_cov[0][31:0];
        o.cov_01 = p_cov[1][31:0];
        o.cov_11 = p_cov[2][31:0];
        o.singular_flag = 0;
        o.saturated_flag = 0;
        pending = {pending, o};
        return;
      end
      n_step++;
      a[0][0] = h16(regs[CFG_A], 0);  a[0][1] = h16(regs[CFG_A], 16);
      a[1][0] = h16(regs[CFG_A], 32); a[1][1] = h16(regs[CFG_A], 48);
      b[0] = h16(regs[CFG_BH], 0);  b[1] = h16(regs[CFG_BH], 16);
      h[0] = h16(regs[CFG_BH], 32); h[1] = h16(regs[CFG_BH], 48);
      q[0][0] = w32(regs[CFG_QD], 0); q[1][1] = w32(regs[CFG_QD], 32);
      q[0][1] = w32(regs[CFG_QR], 0); q[1][0] = q[0][1];
      r = w32(regs[CFG_QR], 32);
      p[0][0] = p_cov[0]; p[0][1] = p_cov[1]; p[1][0] = p_cov[1]; p[1][1] = p_cov[2];
      for (int i = 0; i < 2; i++) begin
        acc = b[i] * u_prev;
        for (int n = 0; n < 2; n++) acc += a[i][n] * x_est[n];
        xe[i] = sat(rnd(acc, COEF_BITS));
      end
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++) begin
          acc = 0;
          for (int n = 0; n < 2; n++) acc += a[i][n] * p[n][j];
          tm[i][j] = sat(rnd(acc, COEF_BITS));
        end
      for (int i = 0; i < 2; i++)
        for (int j = i; j < 2; j++) begin
          acc = 0;
          for (int n = 0; n < 2; n++) acc += tm[i][n] * a[j][n];
          m[i][j] = sat(sat(rnd(acc, COEF_BITS)) + q[i][j]);
          m[j][i] = m[i][j];
        end
      for (int i = 0; i < 2; i++) begin
        acc = 0;
        for (int n = 0; n < 2; n++) acc += m[i][n] * h[n];
        c[i] = sat(rnd(acc, COEF_BITS));
      end
      acc = h[0] * c[0] + h[1] * c[1];
      s = sat(sat(rnd(acc, COEF_BITS)) + r);
      if (s <= 0) begin
        singular = 1;
      end else begin
        for (int i = 0; i < 2; i++) begin
          mag = c[i] < 0 ? -c[i] : c[i];
          quo = ((mag <<< FRAC) + s / 2) / s;
          k[i] = sat(c[i] < 0 ? -quo : quo);
        end
      end
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++)
          g[i][j] = sat(((i == j) ? (longint'(1) <<< FRAC) : 0) - rnd(k[i] * h[j], COEF_BITS));
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++) begin
          acc = 0;
          for (int n = 0; n < 2; n++) acc += rnd(g[i][n] * m[n][j], FRAC);
          um[i][j] = sat(acc);
        end
      for (int i = 0; i < 2; i++) w[i] = sat(rnd(k[i] * r, FRAC));
      for (int i = 0; i < 2; i++)
        for (int j = i; j < 2; j++) begin
          acc = rnd(w[i] * k[j], FRAC);
          for (int n = 0; n < 2; n++) acc += rnd(um[i][n] * g[j][n], FRAC);
          np[i][j] = sat(acc);
        end
      p_cov[0] = np[0][0]; p_cov[1] = np[0][1]; p_cov[2] = np[1][1];
      hx = sat(rnd(h[0] * xe[0] + h[1] * xe[1], COEF_BITS));
      inn = sat(longint'(t.measurement) - hx);
      for (int i = 0; i < 2; i++) x_est[i] = sat(xe[i] + rnd(k[i] * inn, FRAC));
      u_prev = longint'(t.control);
      if (singular) n_singular++;
      if (clamp) n_sat++;
      o.estimate_0 = x_est[0][31:0];
      o.estimate_1 = x_est[1][31:0];
      o.gain_0 = k[0][31:0];
      o.gain_1 = k[1][31:0];
      o.cov_00 = p_cov[0][31:0];
      o.cov_01 = p_cov[1][31:0];
      o.cov_11 = p_cov[2][31:0];
      o.singular_flag = singular;
      o.saturated_flag = clamp;
      pending = {pending, o};
    endfunction

    function bit field_ok(string nm, logic [31:0] e, logic [31:0] a);
      if (e === a) return 1;
      if (mismatches < 10)
        $display("mismatch #%0d on %s: expected %h, got %h", n_checked, nm, e, a);
      return 0;
    endfunction

    function void check_result(kf_out_t got);
      kf_out_t e;
      bit ok;
      if (pending.size() == 0) begin
        if (mismatches < 10) $display("unexpected result transaction: %h", got);
        mismatches++;
        return;
      end
      e = pending.pop_front();
      ok = field_ok("estimate_0", e.estimate_0, got.estimate_0);
      ok &= field_ok("estimate_1", e.estimate_1, got.estimate_1);
      ok &= field_ok("gain_0", e.gain_0, got.gain_0);
      ok &= field_ok("gain_1", e.gain_1, got.gain_1);
      ok &= field_ok("cov_00", e.cov_00, got.cov_00);
      ok &= field_ok("cov_01", e.cov_01, got.cov_01);
      ok &= field_ok("cov_11", e.cov_11, got.cov_11);
      ok &= field_ok("singular_flag", e.singular_flag, got.singular_flag);
      ok &= field_ok("saturated_flag", e.saturated_flag, got.saturated_flag);
      if (!ok) mismatches++;
      n_checked++;
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  kf_in_t      in_data;
  logic        out_valid;
  logic        out_stall;
  kf_out_t     out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;

  kf_scoreboard sb;
  bit calm;
  int idle_cycles;

  kalman_filter_step #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int draw_gap();
    if (calm) return 0;
    return $urandom_range(0, 18);
  endfunction

  // result side: stalls a random number of cycles before each transaction
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      n = draw_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send(logic cmd, logic [31:0] meas, logic [31:0] ctl);
    int n;
    n = draw_gap();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_data <= '{command: cmd, measurement: meas, control: ctl};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (250) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic load_cfg(logic [63:0] am, logic [63:0] bh, logic [63:0] qd,
                          logic [63:0] qr, logic [63:0] x0, logic [63:0] pd,
                          logic [63:0] poff);
    drain();
    write_reg(CFG_A, am);
    write_reg(CFG_BH, bh);
    write_reg(CFG_QD, qd);
    write_reg(CFG_QR, qr);
    write_reg(CFG_X0, x0);
    write_reg(CFG_PD, pd);
    write_reg(CFG_POFF, poff);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] coef(int base, int spread);
    int v;
    v = base + $urandom_range(0, 2 * spread) - spread;
    return v[15:0];
  endfunction

  function automatic logic [31:0] word(int spread);
    int v;
    v = $urandom_range(0, 2 * spread) - spread;
    return v[31:0];
  endfunction

  function automatic logic [63:0] r64();
    return {$urandom, $urandom};
  endfunction

  task automatic tame_cfg();
    load_cfg({coef(4096, 600), coef(0, 800), coef(0, 800), coef(4096, 600)},
             {coef(0, 4096), coef(0, 4096), coef(2048, 4096), coef(0, 4096)},
             {32'($urandom_range(0, 1 << 18)), 32'($urandom_range(0, 1 << 18))},
             {32'($urandom_range(1, 1 << 20)), word(1 << 12)},
             {word(1 << 24), word(1 << 24)},
             {32'($urandom_range(0, 1 << 20)), 32'($urandom_range(0, 1 << 20))},
             {32'h0, word(1 << 14)});
  endtask

  initial begin
    logic [31:0] meas;
    logic [31:0] ctl;
    logic        cmd;
    sb = new();
    calm = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_A;
    cfg_wdata = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // all-zero configuration: S = 0, so the gain is forced to zero
    send(1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
    send(1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
    send(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // identity model, first state observed
    load_cfg({16'h1000, 16'h0, 16'h0, 16'h1000}, {16'h0, 16'h1000, 16'h1000, 16'h0800},
             {32'h0001_0000, 32'h0000_8000}, {32'h0001_0000, 32'h0000_4000},
             {32'h0002_0000, 32'hFFFF_0000}, {32'h0004_0000, 32'h0004_0000},
             {32'h0, 32'h0000_2000});
    send(1'b1, 32'h0, 32'h0);
    send(1'b0, 32'h0001_0000, 32'h0000_8000);
    send(1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
    send(1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
    send(1'b0, 32'h0, 32'h0);
    send(1'b1, 32'h1234_5678, 32'h0);
    send(1'b0, 32'hFFFF_0000, 32'h0001_0000);

    // negative measurement noise with no observation: singular step
    load_cfg({16'h1000, 16'h0, 16'h0, 16'h1000}, 64'h0,
             {32'h0001_0000, 32'h0001_0000}, {32'hFFFF_0000, 32'h0},
             64'h0, {32'h0001_0000, 32'h0001_0000}, 64'h0);
    send(1'b0, 32'h0001_0000, 32'h0);
    send(1'b0, 32'h0002_0000, 32'h0);

    // largest coefficients and words: saturation all over
    load_cfg({4{16'h7FFF}}, {4{16'h8000}}, {2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}},
             {32'h7FFF_FFFF, 32'h8000_0000}, {2{32'h7FFF_FFFF}},
             {32'h0, 32'h7FFF_FFFF});
    send(1'b1, 32'h0, 32'h0);
    send(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send(1'b0, 32'h8000_0000, 32'h8000_0000);
    load_cfg({4{16'hFFFF}}, {4{16'hFFFF}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}},
             {64{1'b1}}, {64{1'b1}});
    send(1'b1, 32'h0, 32'h0);
    send(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(1'b0, 32'h0, 32'h0);

    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 4 == 3) begin
        load_cfg(r64(), r64(), r64(), r64(), r64(), r64(), {32'h0, $urandom});
      end else begin
        tame_cfg();
      end
      calm = (ph % 3 == 1);
      send(1'b1, $urandom, $urandom);
      for (int it = 0; it < 240; it++) begin
        if (it == 120) calm = !calm;
        cmd = ($urandom_range(0, 19) == 0);
        if ($urandom_range(0, 4) == 0) begin
          meas = $urandom;
          ctl = $urandom;
        end else begin
          meas = word(1 << 24);
          ctl = word(1 << 18);
        end
        send(cmd, meas, ctl);
      end
    end

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    $display("covered %0d filter steps and %0d restarts, %0d results checked",
             sb.n_step, sb.n_restart, sb.n_checked);
    $display("singular gain in %0d steps, saturation in %0d steps, %0d mismatches",
             sb.n_singular, sb.n_sat, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
